### rtl/prp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement policy package
// Shared field widths, payload structs, policy codes and sequencer states.
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int PAGE_W  = 11;
  localparam int FRAME_W = 9;
  localparam int TIME_W  = 32;
  localparam int MODE_W  = 3;
  localparam int PAT_W   = 8;

  localparam int PAGE_COUNT_DEF   = 2048;
  localparam int FRAME_COUNT_DEF  = 512;
  localparam int AGING_PERIOD_DEF = 99;

  localparam logic [PAT_W-1:0] AGE_ADD_LRU  = 8'd128;
  localparam logic [PAT_W-1:0] AGE_ADD_FREQ = 8'd126;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIFO  = 3'd0,
    MODE_LRU   = 3'd1,
    MODE_AGING = 3'd2,
    MODE_LFU   = 3'd3,
    MODE_MFU   = 3'd4
  } mode_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_REM,
    S_AGE,
    S_PG_RD,
    S_PG_CHK,
    S_VIC,
    S_F_RD,
    S_F_CHK,
    S_P_RD,
    S_P_WR,
    S_N_RD,
    S_N_WR,
    S_F_WR,
    S_H_RD,
    S_H_WR,
    S_DONE
  } prp_state_e;

  typedef struct packed {
    logic [PAGE_W-1:0] vpage;
    logic [TIME_W-1:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  page_requested;
    logic [FRAME_W-1:0] frame_replaced;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  page_replaced;
  } out_item_t;

  // Victim key: the pattern itself for aging LRU, its population count otherwise.
  function automatic logic [PAT_W-1:0] victim_key(mode_e m, logic [PAT_W-1:0] pat);
    logic [PAT_W-1:0] n;
    n = '0;
    for (int i = 0; i < PAT_W; i++) begin
      n = n + PAT_W'(pat[i]);
    end
    if (m == MODE_AGING) begin
      n = pat;
    end
    return n;
  endfunction

endpackage

### rtl/prp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module prp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/prp_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement aging period check
// Tests the time value for divisibility by the aging period through a reciprocal
// multiplication on one shared 32 by 17 multiplier (low half, high half, back-multiply).
// ----------------------------------------------------------------------------
module prp_rem #(
  parameter int AGING_PERIOD = prp_pkg::AGING_PERIOD_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [prp_pkg::TIME_W-1:0]  value_i,
  output logic                        done_o,
  output logic                        zero_o
);
  import prp_pkg::*;

  localparam int SH    = $clog2(AGING_PERIOD);
  localparam int K     = TIME_W + SH;
  localparam int ACC_W = K + TIME_W;
  localparam int MB    = 17;
  localparam int PW    = TIME_W + MB;
  // Rounded-up reciprocal; with this shift the quotient is exact for every value.
  localparam logic [63:0] RECIP =
    ((64'd1 << K) + 64'(AGING_PERIOD) - 64'd1) / 64'(AGING_PERIOD);
  localparam logic [MB-1:0] M_LO = RECIP[MB-1:0];
  localparam logic [MB-1:0] M_HI = RECIP[2*MB-1:MB];
  localparam logic [MB-1:0] DIV  = MB'(AGING_PERIOD);

  logic              busy_q, done_q, zero_q;
  logic [1:0]        ph_q;
  logic [TIME_W-1:0] v_q;
  logic [ACC_W-1:0]  acc_q;
  logic [TIME_W-1:0] quot;
  logic [TIME_W-1:0] mul_a;
  logic [MB-1:0]     mul_b;
  logic [PW-1:0]     mul_p;

  assign quot = acc_q[K +: TIME_W];

  always_comb begin
    case (ph_q)
      2'd0: begin
        mul_a = v_q;
        mul_b = M_LO;
      end
      2'd1: begin
        mul_a = v_q;
        mul_b = M_HI;
      end
      default: begin
        mul_a = quot;
        mul_b = DIV;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= '0;
      end else if (busy_q) begin
        ph_q <= ph_q + 1'b1;
        if (ph_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= value_i;
    end else if (busy_q) begin
      case (ph_q)
        2'd0: begin
          acc_q <= ACC_W'(mul_p);
        end
        2'd1: begin
          acc_q <= acc_q + (ACC_W'(mul_p) << MB);
        end
        default: begin
          zero_q <= (mul_p == PW'(v_q));
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign zero_o = zero_q;

endmodule

### rtl/page_replacement_policy.sv
`timescale 1ns / 1ps
// A fault into a free frame writes the frame and the page table; an eviction first reads the
// victim frame and may unlink it from inside the recency order. A hit also stalls the input,
// and longer for an LRU move. In the aging modes a period check precedes every request, and an
// aging pass and a victim search each read every frame.
// One request at a time; a result waits in an output register. After reset a clearing pass of
// the page table holds off requests; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// Page replacement policy
// Page and frame tables in RAM with FIFO, LRU, aging LRU, LFU and MFU eviction.
// ----------------------------------------------------------------------------
module page_replacement_policy #(
  parameter int PAGE_COUNT   = prp_pkg::PAGE_COUNT_DEF,
  parameter int FRAME_COUNT  = prp_pkg::FRAME_COUNT_DEF,
  parameter int AGING_PERIOD = prp_pkg::AGING_PERIOD_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [prp_pkg::MODE_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  prp_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output prp_pkg::out_item_t          out_data_o
);
  import prp_pkg::*;

  localparam int PW = $clog2(PAGE_COUNT);
  localparam int FW = $clog2(FRAME_COUNT);
  localparam int CW = FW + 1;

  typedef struct packed {
    logic          valid;
    logic [FW-1:0] frame;
  } pent_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              acc;
    logic [PAT_W-1:0]  pat;
    logic [FW-1:0]     nxt;
    logic [FW-1:0]     prv;
  } fent_t;

  prp_state_e state_q, state_d;
  mode_e      mode_q;

  logic [PAGE_W-1:0] page_q, page_d;
  logic [FW-1:0]     f_q, f_d;
  fent_t             ent_q, ent_d;
  logic              fill_q, fill_d, linked_q, linked_d, evict_q, evict_d;
  logic [FW-1:0]     head_q, head_d, tail_q, tail_d, fifo_q, fifo_d;
  logic [CW-1:0]     used_q, used_d, ctr_q, ctr_d;
  logic              rv_q, rv_d;
  logic [FW-1:0]     ridx_q, ridx_d, best_q, best_d;
  logic [PAT_W-1:0]  bkey_q, bkey_d;
  logic [PW-1:0]     clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              out_load;

  logic          pm_we, pm_re;
  logic [PW-1:0] pm_waddr, pm_raddr;
  pent_t         pm_wdata, pm_rdata;
  logic          fm_we, fm_re;
  logic [FW-1:0] fm_waddr, fm_raddr;
  fent_t         fm_wdata, fm_rdata;

  logic             rem_start, rem_done, rem_zero;
  logic             in_range, full, move;
  logic [PAT_W-1:0] key, age_add;

  prp_ram #(.WIDTH($bits(pent_t)), .DEPTH(PAGE_COUNT)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .re_i    (pm_re),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );

  prp_ram #(.WIDTH($bits(fent_t)), .DEPTH(FRAME_COUNT)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .waddr_i (fm_waddr),
    .wdata_i (fm_wdata),
    .re_i    (fm_re),
    .raddr_i (fm_raddr),
    .rdata_o (fm_rdata)
  );

  prp_rem #(.AGING_PERIOD(AGING_PERIOD)) u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .value_i (in_data_i.time_value),
    .done_o  (rem_done),
    .zero_o  (rem_zero)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_range = (32'(in_data_i.vpage) < PAGE_COUNT);
  assign full     = (used_q >= CW'(FRAME_COUNT));
  assign key      = victim_key(mode_q, fm_rdata.pat);
  assign age_add  = (mode_q == MODE_AGING) ? AGE_ADD_LRU : AGE_ADD_FREQ;
  // The chosen frame moves to the front unless it already heads the order or the
  // order is empty.
  assign move     = !(linked_q && (f_q == head_q)) && (linked_q || (used_q != '0));

  always_comb begin
    state_d     = state_q;
    page_d      = page_q;
    f_d         = f_q;
    ent_d       = ent_q;
    fill_d      = fill_q;
    linked_d    = linked_q;
    evict_d     = evict_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fifo_d      = fifo_q;
    used_d      = used_q;
    ctr_d       = ctr_q;
    rv_d        = 1'b0;
    ridx_d      = ridx_q;
    best_d      = best_q;
    bkey_d      = bkey_q;
    clr_d       = clr_q;
    out_d       = out_q;
    out_load    = 1'b0;
    rem_start   = 1'b0;
    pm_we       = 1'b0;
    pm_waddr    = PW'(page_q);
    pm_wdata    = '0;
    pm_re       = 1'b0;
    pm_raddr    = PW'(page_q);
    fm_we       = 1'b0;
    fm_waddr    = f_q;
    fm_wdata    = fm_rdata;
    fm_re       = 1'b0;
    fm_raddr    = f_q;

    case (state_q)
      S_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == PW'(PAGE_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          page_d = in_data_i.vpage;
          if (!in_range) begin
            state_d = S_IDLE;
          end else if (mode_q >= MODE_AGING) begin
            rem_start = 1'b1;
            state_d   = S_REM;
          end else begin
            state_d = S_PG_RD;
          end
        end
      end
      S_REM: begin
        if (rem_done) begin
          ctr_d   = '0;
          state_d = rem_zero ? S_AGE : S_PG_RD;
        end
      end
      S_AGE: begin
        if (ctr_q < CW'(FRAME_COUNT)) begin
          fm_re    = 1'b1;
          fm_raddr = ctr_q[FW-1:0];
          ctr_d    = ctr_q + 1'b1;
          rv_d     = 1'b1;
          ridx_d   = ctr_q[FW-1:0];
        end
        // Frames never filled are left alone.
        if (rv_q && ({1'b0, ridx_q} < used_q)) begin
          fm_we        = 1'b1;
          fm_waddr     = ridx_q;
          fm_wdata     = fm_rdata;
          fm_wdata.pat = (fm_rdata.pat >> 1) + (fm_rdata.acc ? age_add : '0);
        end
        if ((ctr_q == CW'(FRAME_COUNT)) && !rv_q) begin
          state_d = S_PG_RD;
        end
      end
      S_PG_RD: begin
        pm_re   = 1'b1;
        state_d = S_PG_CHK;
      end
      S_PG_CHK: begin
        if (pm_rdata.valid) begin
          if (mode_q == MODE_LRU) begin
            f_d      = pm_rdata.frame;
            fill_d   = 1'b0;
            linked_d = 1'b1;
            evict_d  = 1'b0;
            state_d  = S_F_RD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          fill_d   = 1'b1;
          linked_d = full;
          evict_d  = full;
          if (!full) begin
            f_d     = used_q[FW-1:0];
            state_d = S_F_WR;
          end else begin
            case (mode_q)
              MODE_FIFO: begin
                f_d     = fifo_q;
                fifo_d  = (fifo_q == FW'(FRAME_COUNT - 1)) ? '0 : fifo_q + 1'b1;
                state_d = S_F_RD;
              end
              MODE_LRU: begin
                f_d     = tail_q;
                state_d = S_F_RD;
              end
              default: begin
                ctr_d   = '0;
                state_d = S_VIC;
              end
            endcase
          end
        end
      end
      S_VIC: begin
        if (ctr_q < CW'(FRAME_COUNT)) begin
          fm_re    = 1'b1;
          fm_raddr = ctr_q[FW-1:0];
          ctr_d    = ctr_q + 1'b1;
          rv_d     = 1'b1;
          ridx_d   = ctr_q[FW-1:0];
        end
        // Strict comparison keeps the lowest-numbered frame on a tie.
        if (rv_q && ((ridx_q == '0) ||
                     ((mode_q == MODE_MFU) ? (key > bkey_q) : (key < bkey_q)))) begin
          bkey_d = key;
          best_d = ridx_q;
        end
        if ((ctr_q == CW'(FRAME_COUNT)) && !rv_q) begin
          f_d     = best_q;
          state_d = S_F_RD;
        end
      end
      S_F_RD: begin
        fm_re   = 1'b1;
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        ent_d = fm_rdata;
        if (fill_q && (32'(fm_rdata.page) < PAGE_COUNT)) begin
          pm_we    = 1'b1;
          pm_waddr = PW'(fm_rdata.page);
        end
        state_d = (f_q == head_q) ? S_F_WR : S_P_RD;
      end
      S_P_RD: begin
        fm_re    = 1'b1;
        fm_raddr = ent_q.prv;
        state_d  = S_P_WR;
      end
      S_P_WR: begin
        fm_we        = 1'b1;
        fm_waddr     = ent_q.prv;
        fm_wdata.nxt = ent_q.nxt;
        if (f_q == tail_q) begin
          tail_d  = ent_q.prv;
          state_d = S_F_WR;
        end else begin
          state_d = S_N_RD;
        end
      end
      S_N_RD: begin
        fm_re    = 1'b1;
        fm_raddr = ent_q.nxt;
        state_d  = S_N_WR;
      end
      S_N_WR: begin
        fm_we        = 1'b1;
        fm_waddr     = ent_q.nxt;
        fm_wdata.prv = ent_q.prv;
        state_d      = S_F_WR;
      end
      S_F_WR: begin
        fm_we    = 1'b1;
        fm_wdata = ent_q;
        if (fill_q) begin
          fm_wdata.page = page_q;
          fm_wdata.acc  = (mode_q >= MODE_AGING);
          fm_wdata.pat  = '0;
        end
        if (move) begin
          fm_wdata.nxt = head_q;
          state_d      = S_H_RD;
        end else begin
          if (!linked_q) begin
            head_d = f_q;
            tail_d = f_q;
          end
          state_d = S_DONE;
        end
      end
      S_H_RD: begin
        fm_re    = 1'b1;
        fm_raddr = head_q;
        state_d  = S_H_WR;
      end
      S_H_WR: begin
        fm_we        = 1'b1;
        fm_waddr     = head_q;
        fm_wdata.prv = f_q;
        head_d       = f_q;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!fill_q) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          pm_we                = 1'b1;
          pm_wdata.valid       = 1'b1;
          pm_wdata.frame       = f_q;
          out_load             = 1'b1;
          out_d.page_requested = page_q;
          out_d.frame_replaced = FRAME_W'(f_q);
          out_d.evicted_valid  = evict_q;
          out_d.page_replaced  = evict_q ? ent_q.page : '0;
          if (!evict_q) begin
            used_d = used_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = (out_valid_q && out_stall_i) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      mode_q      <= MODE_FIFO;
      head_q      <= '0;
      tail_q      <= '0;
      fifo_q      <= '0;
      used_q      <= '0;
      ctr_q       <= '0;
      rv_q        <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      fill_q      <= 1'b0;
      linked_q    <= 1'b0;
      evict_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fifo_q      <= fifo_d;
      used_q      <= used_d;
      ctr_q       <= ctr_d;
      rv_q        <= rv_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
      linked_q    <= linked_d;
      evict_q     <= evict_d;
      if (cfg_valid_i && cfg_ready_o) begin
        // Unused codes behave as FIFO.
        mode_q <= (cfg_wdata_i > MODE_W'(MODE_MFU)) ? MODE_FIFO : mode_e'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    f_q    <= f_d;
    ent_q  <= ent_d;
    ridx_q <= ridx_d;
    best_q <= best_d;
    bkey_q <= bkey_d;
    out_q  <= out_d;
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(FRAME_COUNT))
    else $error("frame fill count exceeds the number of frames");

  a_used_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CLEAR |=> used_q >= $past(used_q))
    else $error("frame fill count went down");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_d.evicted_valid |-> used_q == CW'(FRAME_COUNT))
    else $error("eviction reported while free frames remain");

  a_age_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fm_we && (state_q == S_AGE) |-> {1'b0, fm_waddr} < used_q)
    else $error("aging pass wrote a frame that was never filled");

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fifo_q) < FRAME_COUNT)
    else $error("FIFO pointer out of range");

endmodule
